// File: sv/red_blob_line_centroid_steer_defines.svh
// Assertion helpers for the block's top-level RTL.
// Each expects clk_i and rst_ni in scope.
`ifndef RED_BLOB_LINE_CENTROID_STEER_DEFINES_SVH
`define RED_BLOB_LINE_CENTROID_STEER_DEFINES_SVH

// Same-cycle implication
`define RBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rbc_pkg.sv
package rbc_pkg;

  // Line length default
  localparam int unsigned MAX_PIXELS_DEF = 1024;

  // Fixed field widths
  localparam int unsigned PIXEL_W     = 16;
  localparam int unsigned COLOUR_W    = 8;
  localparam int unsigned CENTRE_W    = 10;
  localparam int unsigned CENTROID_W  = 10;
  localparam int unsigned HIT_TOTAL_W = 11;
  localparam int unsigned STEER_W     = 3;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 10;

  // Result packing: centroid, hit_total, steer, left_lamp, right_lamp
  localparam int unsigned M_FIELDS_W = CENTROID_W + HIT_TOTAL_W + STEER_W + 2;
  localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned M_PAD_W    = M_TDATA_W - M_FIELDS_W;

  // Lines held between front and back end
  localparam int unsigned QUEUE_DEPTH = 2;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_RED_MIN      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GREEN_MAX    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BLUE_MAX     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTRE       = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SEARCH_RIGHT = 3'd5;

  // Register reset values
  localparam logic [COLOUR_W-1:0] RED_MIN_RST   = 8'd90;
  localparam logic [COLOUR_W-1:0] GREEN_MAX_RST = 8'd70;
  localparam logic [COLOUR_W-1:0] BLUE_MAX_RST  = 8'd70;
  localparam logic [CENTRE_W-1:0] CENTRE_RST    = 10'd320;
  localparam logic [CENTRE_W-1:0] DEADBAND_RST  = 10'd15;

  typedef enum logic [STEER_W-1:0] {
    STEER_SEARCH_LEFT  = 3'd0,
    STEER_SEARCH_RIGHT = 3'd1,
    STEER_TURN_LEFT    = 3'd2,
    STEER_TURN_RIGHT   = 3'd3,
    STEER_APPROACH     = 3'd4
  } steer_e;

  typedef struct packed {
    logic [COLOUR_W-1:0] red_min;
    logic [COLOUR_W-1:0] green_max;
    logic [COLOUR_W-1:0] blue_max;
    logic [CENTRE_W-1:0] centre;
    logic [CENTRE_W-1:0] deadband;
    logic                search_right;
  } cfg_t;

endpackage

// File: sv/rbc_front.sv
module rbc_front #(
  parameter int unsigned MAX_PIXELS = rbc_pkg::MAX_PIXELS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  rbc_pkg::cfg_t                                 cfg_i,
  input  logic                                          valid_i,
  output logic                                          ready_o,
  input  logic [rbc_pkg::PIXEL_W-1:0]                   pixel_i,
  input  logic                                          last_i,
  output logic                                          push_o,
  input  logic                                          push_ready_i,
  output logic [$clog2(MAX_PIXELS*(MAX_PIXELS-1)/2+1)-1:0] sum_o,
  output logic [$clog2(MAX_PIXELS+1)-1:0]               cnt_o
);

  localparam int unsigned SUM_MAX = MAX_PIXELS * (MAX_PIXELS - 1) / 2;
  localparam int unsigned SUM_W   = $clog2(SUM_MAX + 1);
  localparam int unsigned POS_W   = $clog2(MAX_PIXELS + 1);
  localparam int unsigned CNT_W   = $clog2(MAX_PIXELS + 1);

  logic [POS_W-1:0] pos_q, pos_d, pos_nxt;
  logic [SUM_W-1:0] sum_q, sum_d, sum_nxt;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_nxt;
  logic [rbc_pkg::COLOUR_W-1:0] red, green, blue;
  logic in_range, hit, take;

  // A line's totals need a free queue slot before any pixel is taken
  assign ready_o = push_ready_i;
  assign take    = valid_i && ready_o;

  // RGB565 to 8-bit channels, low bits zero
  assign red   = {pixel_i[15:11], 3'b000};
  assign green = {pixel_i[10:5], 2'b00};
  assign blue  = {pixel_i[4:0], 3'b000};

  // Pixels beyond MAX_PIXELS in a line are ignored
  assign in_range = pos_q < POS_W'(MAX_PIXELS);
  assign hit = in_range && (red >= cfg_i.red_min) && (green <= cfg_i.green_max)
               && (blue <= cfg_i.blue_max);

  assign sum_nxt = hit ? sum_q + SUM_W'(pos_q) : sum_q;
  assign cnt_nxt = hit ? cnt_q + CNT_W'(1) : cnt_q;
  assign pos_nxt = in_range ? pos_q + POS_W'(1) : pos_q;

  // Totals including the last pixel go straight to the queue
  assign push_o = take && last_i;
  assign sum_o  = sum_nxt;
  assign cnt_o  = cnt_nxt;

  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (take) begin
      if (last_i) begin
        pos_d = '0;
        sum_d = '0;
        cnt_d = '0;
      end else begin
        pos_d = pos_nxt;
        sum_d = sum_nxt;
        cnt_d = cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: sv/rbc_queue.sv
module rbc_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = rbc_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign push_ready_o = cnt_q != CNT_W'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = slot_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Pointer wrap and occupancy
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: sv/rbc_back.sv
module rbc_back #(
  parameter int unsigned MAX_PIXELS = rbc_pkg::MAX_PIXELS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  rbc_pkg::cfg_t                                 cfg_i,
  input  logic                                          pop_valid_i,
  output logic                                          pop_o,
  input  logic [$clog2(MAX_PIXELS*(MAX_PIXELS-1)/2+1)-1:0] sum_i,
  input  logic [$clog2(MAX_PIXELS+1)-1:0]               cnt_i,
  output logic                                          busy_o,
  output logic                                          valid_o,
  input  logic                                          ready_i,
  output logic                                          found_o,
  output logic [rbc_pkg::CENTROID_W-1:0]                centroid_o,
  output logic [rbc_pkg::HIT_TOTAL_W-1:0]               hit_total_o,
  output rbc_pkg::steer_e                               steer_o,
  output logic                                          left_lamp_o,
  output logic                                          right_lamp_o
);

  localparam int unsigned SUM_MAX = MAX_PIXELS * (MAX_PIXELS - 1) / 2;
  localparam int unsigned SUM_W   = $clog2(SUM_MAX + 1);
  localparam int unsigned CNT_W   = $clog2(MAX_PIXELS + 1);
  localparam int unsigned CEN_W   = $clog2(MAX_PIXELS);
  localparam int unsigned STEP_W  = $clog2(SUM_W + 1);
  localparam int unsigned CMP_W   =
    ((CEN_W > rbc_pkg::CENTRE_W) ? CEN_W : rbc_pkg::CENTRE_W) + 1;

  localparam int unsigned STATE_W = 2;
  localparam logic [STATE_W-1:0] ST_IDLE = 2'd0;
  localparam logic [STATE_W-1:0] ST_DIV  = 2'd1;
  localparam logic [STATE_W-1:0] ST_FIN  = 2'd2;

  logic [STATE_W-1:0] state_q, state_d;
  logic [CNT_W:0]     rem_q, rem_d, rem_sh;
  logic [SUM_W-1:0]   quo_q, quo_d;
  logic [CNT_W-1:0]   div_q, div_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               ge;

  logic                           valid_q, valid_d;
  logic                           found_q, found_d;
  logic [rbc_pkg::CENTROID_W-1:0] centroid_q, centroid_d;
  logic [rbc_pkg::HIT_TOTAL_W-1:0] hit_q, hit_d;
  rbc_pkg::steer_e                steer_q, steer_d;
  logic                           left_q, left_d, right_q, right_d;

  logic [CEN_W-1:0] cen;
  logic [CMP_W-1:0] cen_x, ctr_x, db_x;
  logic             found, load;

  // One restoring division step per cycle
  assign rem_sh = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, div_q};

  // Result formation
  assign found = div_q != '0;
  assign cen   = CEN_W'(quo_q);
  assign cen_x = CMP_W'(cen);
  assign ctr_x = CMP_W'(cfg_i.centre);
  assign db_x  = CMP_W'(cfg_i.deadband);
  assign load  = (state_q == ST_FIN) && (!valid_q || ready_i);

  assign pop_o  = (state_q == ST_IDLE) && pop_valid_i;
  assign busy_o = state_q != ST_IDLE;

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    div_d   = div_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          rem_d   = '0;
          quo_d   = sum_i;
          div_d   = cnt_i;
          step_d  = STEP_W'(SUM_W);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = ge ? rem_sh - {1'b0, div_q} : rem_sh;
        quo_d  = (quo_q << 1) | SUM_W'(ge);
        step_d = step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: holds a result until the sink takes it
  always_comb begin
    valid_d    = valid_q && !ready_i;
    found_d    = found_q;
    centroid_d = centroid_q;
    hit_d      = hit_q;
    steer_d    = steer_q;
    left_d     = left_q;
    right_d    = right_q;
    if (load) begin
      valid_d    = 1'b1;
      found_d    = found;
      centroid_d = found ? rbc_pkg::CENTROID_W'(cen) : '0;
      hit_d      = rbc_pkg::HIT_TOTAL_W'(div_q);
      left_d     = found && (cen_x < ctr_x);
      right_d    = found && !(cen_x < ctr_x);
      if (!found) begin
        steer_d = cfg_i.search_right ? rbc_pkg::STEER_SEARCH_RIGHT
                                     : rbc_pkg::STEER_SEARCH_LEFT;
      end else if (ctr_x > cen_x + db_x) begin
        steer_d = rbc_pkg::STEER_TURN_LEFT;
      end else if (cen_x > ctr_x + db_x) begin
        steer_d = rbc_pkg::STEER_TURN_RIGHT;
      end else begin
        steer_d = rbc_pkg::STEER_APPROACH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    div_q      <= div_d;
    step_q     <= step_d;
    found_q    <= found_d;
    centroid_q <= centroid_d;
    hit_q      <= hit_d;
    steer_q    <= steer_d;
    left_q     <= left_d;
    right_q    <= right_d;
  end

  assign valid_o      = valid_q;
  assign found_o      = found_q;
  assign centroid_o   = centroid_q;
  assign hit_total_o  = hit_q;
  assign steer_o      = steer_q;
  assign left_lamp_o  = left_q;
  assign right_lamp_o = right_q;

endmodule

// File: sv/red_blob_line_centroid_steer.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata pixel, tlast end of line
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata line result, tuser found
// cfg       in   cfg_valid_i/cfg_ready_o        cfg_addr_i register, cfg_data_i
//
// Front end takes one pixel per cycle; classification and accumulation are
// done as each pixel is taken. Each line's totals pass through a two-line queue
// to the back end, whose shared restoring divider takes one step per bit of
// SUM_W, the position-sum width. Pixels stall only while the queue is full.
// A result waits in the output register while further lines are accumulated.
// Reset clears counters, queue occupancy, back-end state and output valid at once.
`include "red_blob_line_centroid_steer_defines.svh"

module red_blob_line_centroid_steer #(
  parameter int unsigned MAX_PIXELS = rbc_pkg::MAX_PIXELS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // stream in
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rbc_pkg::PIXEL_W-1:0]       s_axis_tdata,   // [15:0] pixel
  input  logic                              s_axis_tlast,
  // stream out
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [9:0] centroid, [20:10] hit_total, [23:21] steer, [24] left_lamp,
  // [25] right_lamp, rest zero
  output logic [rbc_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  output logic                              m_axis_tuser,   // [0] found
  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rbc_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [rbc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned SUM_W = $clog2(MAX_PIXELS * (MAX_PIXELS - 1) / 2 + 1);
  localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int unsigned Q_W   = SUM_W + CNT_W;

  rbc_pkg::cfg_t cfg_q, cfg_d;

  logic             push, push_ready, pop, pop_valid, back_busy;
  logic [SUM_W-1:0] fr_sum, bk_sum;
  logic [CNT_W-1:0] fr_cnt, bk_cnt;
  logic [Q_W-1:0]   q_out;

  logic                            found;
  logic [rbc_pkg::CENTROID_W-1:0]  centroid;
  logic [rbc_pkg::HIT_TOTAL_W-1:0] hit_total;
  rbc_pkg::steer_e                 steer;
  logic                            left_lamp, right_lamp;

  // Register file; writes are always taken, unknown indexes dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_addr_i)
        rbc_pkg::REG_RED_MIN:      cfg_d.red_min      = cfg_data_i[rbc_pkg::COLOUR_W-1:0];
        rbc_pkg::REG_GREEN_MAX:    cfg_d.green_max    = cfg_data_i[rbc_pkg::COLOUR_W-1:0];
        rbc_pkg::REG_BLUE_MAX:     cfg_d.blue_max     = cfg_data_i[rbc_pkg::COLOUR_W-1:0];
        rbc_pkg::REG_CENTRE:       cfg_d.centre       = cfg_data_i[rbc_pkg::CENTRE_W-1:0];
        rbc_pkg::REG_DEADBAND:     cfg_d.deadband     = cfg_data_i[rbc_pkg::CENTRE_W-1:0];
        rbc_pkg::REG_SEARCH_RIGHT: cfg_d.search_right = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_min      <= rbc_pkg::RED_MIN_RST;
      cfg_q.green_max    <= rbc_pkg::GREEN_MAX_RST;
      cfg_q.blue_max     <= rbc_pkg::BLUE_MAX_RST;
      cfg_q.centre       <= rbc_pkg::CENTRE_RST;
      cfg_q.deadband     <= rbc_pkg::DEADBAND_RST;
      cfg_q.search_right <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Pixel classification and line accumulation
  rbc_front #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .pixel_i      (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .push_o       (push),
    .push_ready_i (push_ready),
    .sum_o        (fr_sum),
    .cnt_o        (fr_cnt)
  );

  // Line totals queue
  rbc_queue #(
    .WIDTH (Q_W),
    .DEPTH (rbc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  ({fr_sum, fr_cnt}),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (q_out)
  );

  assign bk_sum = q_out[Q_W-1:CNT_W];
  assign bk_cnt = q_out[CNT_W-1:0];

  // Division, steering and output register
  rbc_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pop_valid_i  (pop_valid),
    .pop_o        (pop),
    .sum_i        (bk_sum),
    .cnt_i        (bk_cnt),
    .busy_o       (back_busy),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .found_o      (found),
    .centroid_o   (centroid),
    .hit_total_o  (hit_total),
    .steer_o      (steer),
    .left_lamp_o  (left_lamp),
    .right_lamp_o (right_lamp)
  );

  assign m_axis_tdata = {{rbc_pkg::M_PAD_W{1'b0}}, right_lamp, left_lamp, steer,
                         hit_total, centroid};
  assign m_axis_tuser = found;

  // Checks
  `RBC_ASSERT_IMP(a_none_blank, m_axis_tvalid && !found,
    centroid == '0 && !left_lamp && !right_lamp, "empty line result not blank")
  `RBC_ASSERT_IMP(a_one_lamp, m_axis_tvalid && found,
    $onehot({left_lamp, right_lamp}), "found result must light one lamp")
  `RBC_ASSERT_IMP(a_steer_kind, m_axis_tvalid,
    found ? (steer == rbc_pkg::STEER_TURN_LEFT || steer == rbc_pkg::STEER_TURN_RIGHT
             || steer == rbc_pkg::STEER_APPROACH)
          : (steer == rbc_pkg::STEER_SEARCH_LEFT || steer == rbc_pkg::STEER_SEARCH_RIGHT),
    "steer code disagrees with found")
  `RBC_ASSERT_NEXT(a_pop_busy, pop, back_busy, "back end idle after taking a line")

endmodule

// File: verif/tb.sv
module tb;
  import rbc_pkg::*;

  localparam int unsigned LINE_MAX    = MAX_PIXELS_DEF;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;

  // One pixel transaction waiting to be offered
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               last;
  } pixel_item_t;

  // What the block should report at the end of a line
  typedef struct {
    bit                     found;
    logic [CENTROID_W-1:0]  centroid;
    logic [HIT_TOTAL_W-1:0] hit_total;
    steer_e                 steer;
    bit                     left_lamp;
    bit                     right_lamp;
  } line_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [PIXEL_W-1:0]    s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  pixel_item_t  pixel_feed[$];
  line_result_t pending_line_results[$];
  int           mismatches = 0;

  // Stimulus-side copy of the thresholds, used to bias pixels towards hits
  cfg_t stim_cfg;

  // Predictor state: its own register copy and line accumulators
  cfg_t        line_cfg = '{RED_MIN_RST, GREEN_MAX_RST, BLUE_MAX_RST, CENTRE_RST,
                            DEADBAND_RST, 1'b0};
  int unsigned line_pos = 0;
  int unsigned pos_sum = 0;
  int unsigned hit_cnt = 0;

  // Traffic shaping
  bit calm = 1'b0;
  bit hold_armed = 1'b0;
  bit hold_done;
  int hold_left;
  int quiet_cycles = 0;

  red_blob_line_centroid_steer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Colour expansion without low-bit replication, then the threshold test
  function automatic bit colour_match(logic [PIXEL_W-1:0] px, cfg_t c);
    logic [7:0] red, green, blue;
    red   = {px[15:11], 3'b000};
    green = {px[10:5], 2'b00};
    blue  = {px[4:0], 3'b000};
    return (red >= c.red_min) && (green <= c.green_max) && (blue <= c.blue_max);
  endfunction

  // Register write as the block sees it; unknown indexes change nothing
  task automatic apply_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_RED_MIN:      line_cfg.red_min = val[COLOUR_W-1:0];
      REG_GREEN_MAX:    line_cfg.green_max = val[COLOUR_W-1:0];
      REG_BLUE_MAX:     line_cfg.blue_max = val[COLOUR_W-1:0];
      REG_CENTRE:       line_cfg.centre = val[CENTRE_W-1:0];
      REG_DEADBAND:     line_cfg.deadband = val[CENTRE_W-1:0];
      REG_SEARCH_RIGHT: line_cfg.search_right = val[0];
      default: ;
    endcase
  endtask

  // Accumulate one pixel; the end of a line yields the steering result
  task automatic take_pixel(logic [PIXEL_W-1:0] px, logic last);
    line_result_t res;
    int           offset;
    int unsigned  mean;
    if (line_pos < LINE_MAX) begin
      if (colour_match(px, line_cfg)) begin
        pos_sum += line_pos;
        hit_cnt++;
      end
      line_pos++;
    end
    if (last) begin
      res.found      = hit_cnt != 0;
      res.hit_total  = HIT_TOTAL_W'(hit_cnt);
      res.left_lamp  = 1'b0;
      res.right_lamp = 1'b0;
      if (res.found) begin
        mean         = pos_sum / hit_cnt;
        res.centroid = CENTROID_W'(mean);
        if (mean < line_cfg.centre) res.left_lamp = 1'b1;
        else res.right_lamp = 1'b1;
        offset = int'(line_cfg.centre) - int'(mean);
        if (offset > int'(line_cfg.deadband)) res.steer = STEER_TURN_LEFT;
        else if (offset < -int'(line_cfg.deadband)) res.steer = STEER_TURN_RIGHT;
        else res.steer = STEER_APPROACH;
      end else begin
        res.centroid = '0;
        res.steer    = line_cfg.search_right ? STEER_SEARCH_RIGHT : STEER_SEARCH_LEFT;
      end
      pending_line_results.push_back(res);
      line_pos = 0;
      pos_sum  = 0;
      hit_cnt  = 0;
    end
  endtask

  task automatic compare_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Monitor: register writes, pixel transactions and result transactions
  always @(posedge clk_i) begin : observe
    line_result_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) apply_write(cfg_addr_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) take_pixel(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_line_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                   $time, m_axis_tdata, m_axis_tuser);
          mismatches++;
        end else begin
          want = pending_line_results.pop_front();
          compare_field("found", want.found, m_axis_tuser);
          compare_field("centroid", want.centroid, m_axis_tdata[CENTROID_W-1:0]);
          compare_field("hit_total", want.hit_total,
                        m_axis_tdata[CENTROID_W +: HIT_TOTAL_W]);
          compare_field("steer", want.steer,
                        m_axis_tdata[CENTROID_W+HIT_TOTAL_W +: STEER_W]);
          compare_field("left_lamp", want.left_lamp, m_axis_tdata[M_FIELDS_W-2]);
          compare_field("right_lamp", want.right_lamp, m_axis_tdata[M_FIELDS_W-1]);
          compare_field("padding", 0, m_axis_tdata >> M_FIELDS_W);
        end
      end
    end
  end

  // Pixel driver: next item once the current one is taken, with random gaps
  always @(posedge clk_i or negedge rst_ni) begin : pixel_driver
    pixel_item_t item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pixel_feed.size() != 0 && (calm || $urandom_range(0, 99) >= 18)) begin
        item = pixel_feed.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item.pixel;
        s_axis_tlast  <= item.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off when armed
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 18);
    end
  end

  // Watchdog on cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Random pixel, about half of them drawn near the current hit region
  function automatic logic [PIXEL_W-1:0] make_pixel();
    int unsigned r_lo, g_hi, b_hi;
    logic [4:0]  r5, b5;
    logic [5:0]  g6;
    if ($urandom_range(0, 99) < 45) return PIXEL_W'($urandom_range(0, 16'hFFFF));
    r_lo = (stim_cfg.red_min + 7) / 8;
    if (r_lo > 31) r_lo = 31;
    g_hi = stim_cfg.green_max / 4 + 1;
    if (g_hi > 63) g_hi = 63;
    b_hi = stim_cfg.blue_max / 8 + 1;
    if (b_hi > 31) b_hi = 31;
    r5 = 5'($urandom_range(r_lo, 31));
    g6 = 6'($urandom_range(0, g_hi));
    b5 = 5'($urandom_range(0, b_hi));
    return {r5, g6, b5};
  endfunction

  task automatic push_pixel(logic [PIXEL_W-1:0] px, logic last);
    pixel_item_t item;
    item.pixel = px;
    item.last  = last;
    pixel_feed.push_back(item);
  endtask

  task automatic push_line(int unsigned len);
    for (int unsigned i = 0; i < len; i++) push_pixel(make_pixel(), i == len - 1);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Write every register from stim_cfg; upper data bits of the narrow ones
  // carry junk that must be dropped, and sometimes an unused index is hit
  task automatic load_config();
    logic [1:0] junk;
    junk = 2'($urandom_range(0, 3));
    @(posedge clk_i);
    cfg_write(REG_RED_MIN, {junk, stim_cfg.red_min});
    cfg_write(REG_GREEN_MAX, {~junk, stim_cfg.green_max});
    cfg_write(REG_BLUE_MAX, {junk, stim_cfg.blue_max});
    cfg_write(REG_CENTRE, stim_cfg.centre);
    cfg_write(REG_DEADBAND, stim_cfg.deadband);
    cfg_write(REG_SEARCH_RIGHT, {9'($urandom_range(0, 511)), stim_cfg.search_right});
    if ($urandom_range(0, 1))
      cfg_write(CFG_ADDR_W'(REG_SEARCH_RIGHT + 1 + $urandom_range(0, 1)),
                CFG_DATA_W'($urandom_range(0, 1023)));
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every pixel is taken and every line result has arrived
  task automatic drain();
    while (pixel_feed.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (pending_line_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  initial begin
    int unsigned count, len;
    stim_cfg = '{RED_MIN_RST, GREEN_MAX_RST, BLUE_MAX_RST, CENTRE_RST, DEADBAND_RST, 1'b0};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines at reset thresholds: black, white, pure red, then
    // pixels on either side of each colour limit with a hit as last pixel
    push_pixel(16'h0000, 1'b1);
    push_pixel(16'hFFFF, 1'b1);
    push_pixel(16'hF800, 1'b1);
    push_pixel({5'd11, 6'd0, 5'd0}, 1'b0);
    push_pixel({5'd12, 6'd0, 5'd0}, 1'b0);
    push_pixel({5'd12, 6'd17, 5'd8}, 1'b0);
    push_pixel({5'd12, 6'd18, 5'd0}, 1'b0);
    push_pixel({5'd12, 6'd0, 5'd9}, 1'b0);
    push_pixel({5'd12, 6'd17, 5'd8}, 1'b1);
    drain();

    // Random phases, extremes of the registers first
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: stim_cfg = '{8'd0, 8'd255, 8'd255, 10'd0, 10'd0, 1'b1};
        1: stim_cfg = '{8'd255, 8'd0, 8'd0, 10'd1023, 10'd1023, 1'b0};
        2: stim_cfg = '{8'd248, 8'd0, 8'd0, 10'd1023, 10'd0, 1'b1};
        3: stim_cfg = '{8'd0, 8'd255, 8'd255, 10'd0, 10'd1023, 1'b0};
        default: begin
          stim_cfg.red_min      = COLOUR_W'($urandom_range(0, 255));
          stim_cfg.green_max    = COLOUR_W'($urandom_range(0, 255));
          stim_cfg.blue_max     = COLOUR_W'($urandom_range(0, 255));
          stim_cfg.centre       = CENTRE_W'($urandom_range(0, 60));
          stim_cfg.deadband     = CENTRE_W'($urandom_range(0, 12));
          stim_cfg.search_right = 1'($urandom_range(0, 1));
        end
      endcase
      load_config();
      calm       <= (ph == 5);
      hold_armed <= (ph == 7);
      count = 0;
      while (count < 80) begin
        if (ph == 7) len = $urandom_range(1, 3);
        else if ($urandom_range(0, 9) == 0) len = $urandom_range(49, 150);
        else len = $urandom_range(1, 48);
        push_line(len);
        count += len;
      end
      drain();
    end
    calm <= 1'b0;

    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending_line_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
